// ===== rtl/core/tcbdq_pkg.sv =====
// Package for the two-class byte drain queue.
// Field widths, transfer codes, source codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package tcbdq_pkg;

  // Payload field widths
  localparam int MSG_LEN_W     = 10;
  localparam int DRAIN_W       = 16;
  localparam int TOTAL_BYTES_W = 17;
  localparam int TOTAL_MSG_W   = 8;

  // Largest message accepted, in bytes
  localparam logic [MSG_LEN_W-1:0] MAX_MSG_BYTES = 10'd512;

  // Default FIFO depth in entries
  localparam int FIFO_DEPTH_DEF = 64;

  // Item mode codes
  localparam logic MODE_ENQ   = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // Queue of the next segment
  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_NORMAL = 2'd1,
    SRC_PRIO   = 2'd2
  } src_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_STEP
  } state_t;

endpackage

// ===== rtl/core/tcbdq_if.sv =====
// Channel interfaces for the two-class byte drain queue.
// Depends on tcbdq_pkg for the payload widths.
`timescale 1ns / 1ps

// Input channel: enqueue or drain request
interface tcbdq_in_if;
  import tcbdq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [MSG_LEN_W-1:0] msg_length;
  logic                 high_priority;
  logic [DRAIN_W-1:0]   drain_bytes;

  modport source (output valid, mode, msg_length, high_priority, drain_bytes,
                  input ready);
  modport sink   (input valid, mode, msg_length, high_priority, drain_bytes,
                  output ready);
endinterface

// Result channel: status after each item
interface tcbdq_out_if;
  import tcbdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic [DRAIN_W-1:0]       bytes_left_over;
  logic [TOTAL_BYTES_W-1:0] total_bytes;
  logic [TOTAL_MSG_W-1:0]   total_messages;
  logic [1:0]               next_source;
  logic [MSG_LEN_W-1:0]     next_remaining;

  modport source (output valid, accepted, bytes_left_over, total_bytes,
                  total_messages, next_source, next_remaining,
                  input ready);
  modport sink   (input valid, accepted, bytes_left_over, total_bytes,
                  total_messages, next_source, next_remaining,
                  output ready);
endinterface

// ===== rtl/core/two_class_byte_drain_queue_unit.sv =====
// Two-class byte drain queue: an enqueue goes through EXEC, LOAD and STEP before its
// result is registered; a drain does too, going back to LOAD for each whole message
// retired and staying in STEP for a partly sent head. The single compare/subtract unit
// steps one head at a time; a new head waits in LOAD for the registered length read.
// One item in flight; the next is taken once the result register is free.
// Synchronous active-low reset empties both FIFOs; length memories are not cleared.
`timescale 1ns / 1ps

module two_class_byte_drain_queue_unit #(
  parameter int FIFO_DEPTH = tcbdq_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  tcbdq_in_if.sink           in_chan,
  tcbdq_out_if.source        out_chan
);
  import tcbdq_pkg::*;

  localparam int AW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW  = $clog2(FIFO_DEPTH + 1);
  localparam int QBW = $clog2(2 * FIFO_DEPTH * int'(MAX_MSG_BYTES) + 1);

  localparam logic [AW-1:0] PTR_LAST  = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FILL_FULL = CW'(FIFO_DEPTH);

  // Length memories
  logic [MSG_LEN_W-1:0] mem_n [FIFO_DEPTH];
  logic [MSG_LEN_W-1:0] mem_p [FIFO_DEPTH];
  logic [MSG_LEN_W-1:0] rd_n_r, rd_p_r;
  logic                 wr_n, wr_p;

  // Queue state
  logic [AW-1:0]        head_n_r, head_n_nxt, tail_n_r, tail_n_nxt;
  logic [AW-1:0]        head_p_r, head_p_nxt, tail_p_r, tail_p_nxt;
  logic [CW-1:0]        fill_n_r, fill_n_nxt, fill_p_r, fill_p_nxt;
  logic [MSG_LEN_W-1:0] sent_n_r, sent_n_nxt, sent_p_r, sent_p_nxt;
  logic [QBW-1:0]       queued_r, queued_nxt;

  // Item latch
  state_t               state_r, state_nxt;
  logic                 mode_r, mode_nxt;
  logic                 hp_r, hp_nxt;
  logic [MSG_LEN_W-1:0] len_r, len_nxt;
  logic [DRAIN_W-1:0]   budget_r, budget_nxt;
  logic                 acc_r, acc_nxt;

  // Result register
  logic                     ov_r, ov_nxt;
  logic                     o_acc_r, o_acc_nxt;
  logic [DRAIN_W-1:0]       o_left_r, o_left_nxt;
  logic [TOTAL_BYTES_W-1:0] o_bytes_r, o_bytes_nxt;
  logic [TOTAL_MSG_W-1:0]   o_msgs_r, o_msgs_nxt;
  src_t                     o_src_r, o_src_nxt;
  logic [MSG_LEN_W-1:0]     o_rem_r, o_rem_nxt;

  // Shared head unit
  src_t                 sel;
  logic [MSG_LEN_W-1:0] sel_len, sel_sent, left;
  logic                 take_whole, finish;
  logic                 in_xfer;
  logic                 enq_ok;
  logic [CW:0]          msg_sum;

  assign in_chan.ready = (state_r == ST_IDLE) && (!ov_r || out_chan.ready);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // Next segment selection and the single compare/subtract on its head
  always_comb begin
    if (fill_n_r != '0 && sent_n_r != '0) begin
      sel = SRC_NORMAL;
    end else if (fill_p_r != '0) begin
      sel = SRC_PRIO;
    end else if (fill_n_r != '0) begin
      sel = SRC_NORMAL;
    end else begin
      sel = SRC_NONE;
    end
    sel_len    = (sel == SRC_PRIO) ? rd_p_r : rd_n_r;
    sel_sent   = (sel == SRC_PRIO) ? sent_p_r : sent_n_r;
    left       = (sel_len > sel_sent) ? sel_len - sel_sent : '0;
    take_whole = budget_r >= DRAIN_W'(left);
    finish     = (budget_r == '0) || (sel == SRC_NONE);
    enq_ok     = (len_r != '0) && (len_r <= MAX_MSG_BYTES) &&
                 (hp_r ? (fill_p_r < FILL_FULL) : (fill_n_r < FILL_FULL));
    msg_sum    = (CW+1)'(fill_n_r) + (CW+1)'(fill_p_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_STEP;
      ST_STEP: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end else if (take_whole) begin
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    head_n_nxt  = head_n_r;
    tail_n_nxt  = tail_n_r;
    head_p_nxt  = head_p_r;
    tail_p_nxt  = tail_p_r;
    fill_n_nxt  = fill_n_r;
    fill_p_nxt  = fill_p_r;
    sent_n_nxt  = sent_n_r;
    sent_p_nxt  = sent_p_r;
    queued_nxt  = queued_r;
    mode_nxt    = mode_r;
    hp_nxt      = hp_r;
    len_nxt     = len_r;
    budget_nxt  = budget_r;
    acc_nxt     = acc_r;
    ov_nxt      = ov_r && !out_chan.ready;
    o_acc_nxt   = o_acc_r;
    o_left_nxt  = o_left_r;
    o_bytes_nxt = o_bytes_r;
    o_msgs_nxt  = o_msgs_r;
    o_src_nxt   = o_src_r;
    o_rem_nxt   = o_rem_r;
    wr_n        = 1'b0;
    wr_p        = 1'b0;

    case (state_r)
      // Latch the item; an enqueue carries no drain budget
      ST_IDLE: begin
        if (in_xfer) begin
          mode_nxt   = in_chan.mode;
          hp_nxt     = in_chan.high_priority;
          len_nxt    = in_chan.msg_length;
          budget_nxt = (in_chan.mode == MODE_DRAIN) ? in_chan.drain_bytes : '0;
        end
      end
      // Enqueue write, or mark the drain as done
      ST_EXEC: begin
        if (mode_r == MODE_ENQ) begin
          acc_nxt = enq_ok;
          if (enq_ok) begin
            queued_nxt = queued_r + QBW'(len_r);
            if (hp_r) begin
              wr_p       = 1'b1;
              tail_p_nxt = (tail_p_r == PTR_LAST) ? '0 : tail_p_r + 1'b1;
              fill_p_nxt = fill_p_r + 1'b1;
            end else begin
              wr_n       = 1'b1;
              tail_n_nxt = (tail_n_r == PTR_LAST) ? '0 : tail_n_r + 1'b1;
              fill_n_nxt = fill_n_r + 1'b1;
            end
          end
        end else begin
          acc_nxt = 1'b1;
        end
      end
      ST_LOAD: begin
      end
      // One head per step; report once the budget is spent or both queues empty
      ST_STEP: begin
        if (finish) begin
          ov_nxt      = 1'b1;
          o_acc_nxt   = acc_r;
          o_left_nxt  = budget_r;
          o_bytes_nxt = TOTAL_BYTES_W'(queued_r);
          o_msgs_nxt  = TOTAL_MSG_W'(msg_sum);
          o_src_nxt   = sel;
          o_rem_nxt   = (sel == SRC_NONE) ? '0 : left;
        end else if (take_whole) begin
          budget_nxt = budget_r - DRAIN_W'(left);
          queued_nxt = queued_r - QBW'(left);
          if (sel == SRC_PRIO) begin
            head_p_nxt = (head_p_r == PTR_LAST) ? '0 : head_p_r + 1'b1;
            fill_p_nxt = fill_p_r - 1'b1;
            sent_p_nxt = '0;
          end else begin
            head_n_nxt = (head_n_r == PTR_LAST) ? '0 : head_n_r + 1'b1;
            fill_n_nxt = fill_n_r - 1'b1;
            sent_n_nxt = '0;
          end
        end else begin
          budget_nxt = '0;
          queued_nxt = queued_r - QBW'(budget_r);
          if (sel == SRC_PRIO) begin
            sent_p_nxt = sent_p_r + MSG_LEN_W'(budget_r);
          end else begin
            sent_n_nxt = sent_n_r + MSG_LEN_W'(budget_r);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Length memories: one write, one registered read at the head each
  always_ff @(posedge clk) begin
    if (wr_n) mem_n[tail_n_r] <= len_r;
    if (wr_p) mem_p[tail_p_r] <= len_r;
    rd_n_r <= mem_n[head_n_r];
    rd_p_r <= mem_p[head_p_r];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_n_r <= '0;
      tail_n_r <= '0;
      head_p_r <= '0;
      tail_p_r <= '0;
      fill_n_r <= '0;
      fill_p_r <= '0;
      sent_n_r <= '0;
      sent_p_r <= '0;
      queued_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_n_r <= head_n_nxt;
      tail_n_r <= tail_n_nxt;
      head_p_r <= head_p_nxt;
      tail_p_r <= tail_p_nxt;
      fill_n_r <= fill_n_nxt;
      fill_p_r <= fill_p_nxt;
      sent_n_r <= sent_n_nxt;
      sent_p_r <= sent_p_nxt;
      queued_r <= queued_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    hp_r      <= hp_nxt;
    len_r     <= len_nxt;
    budget_r  <= budget_nxt;
    acc_r     <= acc_nxt;
    o_acc_r   <= o_acc_nxt;
    o_left_r  <= o_left_nxt;
    o_bytes_r <= o_bytes_nxt;
    o_msgs_r  <= o_msgs_nxt;
    o_src_r   <= o_src_nxt;
    o_rem_r   <= o_rem_nxt;
  end

  assign out_chan.valid           = ov_r;
  assign out_chan.accepted        = o_acc_r;
  assign out_chan.bytes_left_over = o_left_r;
  assign out_chan.total_bytes     = o_bytes_r;
  assign out_chan.total_messages  = o_msgs_r;
  assign out_chan.next_source     = o_src_r;
  assign out_chan.next_remaining  = o_rem_r;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for two_class_byte_drain_queue_unit: directed table, then random phases.
// Depends on tcbdq_pkg, tcbdq_in_if and tcbdq_out_if from the RTL.
// Each result is checked in order against its typed table row or a behavioural model of both FIFOs.
`timescale 1ns / 1ps

module tb_top;
  import tcbdq_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int IDLE_PCT     = 31;
  localparam int SETTLE_CYCLE = 300;
  localparam int MAX_REPORTS  = 10;

  localparam int LANE_NORMAL = 0;
  localparam int LANE_PRIO   = 1;
  localparam int NO_LANE     = -1;

  typedef struct packed {
    logic                 mode;
    logic [MSG_LEN_W-1:0] msg_length;
    logic                 high_priority;
    logic [DRAIN_W-1:0]   drain_bytes;
  } req_t;

  typedef struct packed {
    logic                     accepted;
    logic [DRAIN_W-1:0]       left_over;
    logic [TOTAL_BYTES_W-1:0] total_bytes;
    logic [TOTAL_MSG_W-1:0]   total_msgs;
    src_t                     next_src;
    logic [MSG_LEN_W-1:0]     next_rem;
  } status_t;

  typedef struct packed {
    req_t    req;
    logic    typed;
    status_t want;
  } dir_row_t;

  typedef enum int {PH_FILL, PH_ONE_CLASS, PH_DRAIN, PH_MIXED} phase_t;

  logic clk;
  logic rst_n;

  tcbdq_in_if  in_chan ();
  tcbdq_out_if out_chan ();

  two_class_byte_drain_queue_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Model state: lengths per lane, sent offset of each head, unsent total
  int unsigned lane_len [2][$];
  int unsigned lane_sent [2];
  int unsigned queued_total;

  status_t pending_status [$];

  int  mismatches;
  int  results_seen;
  int  cycle_count;
  int  n_enq, n_drain, n_full_refused, n_bad_len, n_multi_retire, peak_msgs;
  bit  calm;

  // Directed table; typed expectations follow the queue by hand from reset
  dir_row_t dir_rows [25] = '{
    // empty queue, zero drain and oversized drain
    '{'{MODE_DRAIN, 10'd0,    1'b0, 16'd0},     1'b1,
      '{1'b1, 16'd0,     17'd0,    8'd0, SRC_NONE,   10'd0}},
    '{'{MODE_DRAIN, 10'd0,    1'b1, 16'd65535}, 1'b1,
      '{1'b1, 16'd65535, 17'd0,    8'd0, SRC_NONE,   10'd0}},
    // bad lengths refused
    '{'{MODE_ENQ,   10'd0,    1'b0, 16'd0},     1'b1,
      '{1'b0, 16'd0,     17'd0,    8'd0, SRC_NONE,   10'd0}},
    '{'{MODE_ENQ,   10'd513,  1'b1, 16'd0},     1'b1,
      '{1'b0, 16'd0,     17'd0,    8'd0, SRC_NONE,   10'd0}},
    '{'{MODE_ENQ,   10'd1023, 1'b0, 16'hFFFF},  1'b1,
      '{1'b0, 16'd0,     17'd0,    8'd0, SRC_NONE,   10'd0}},
    // length extremes on both lanes; priority takes the lead
    '{'{MODE_ENQ,   10'd1,    1'b0, 16'd0},     1'b1,
      '{1'b1, 16'd0,     17'd1,    8'd1, SRC_NORMAL, 10'd1}},
    '{'{MODE_ENQ,   10'd512,  1'b1, 16'd0},     1'b1,
      '{1'b1, 16'd0,     17'd513,  8'd2, SRC_PRIO,   10'd512}},
    '{'{MODE_ENQ,   10'd512,  1'b0, 16'd0},     1'b1,
      '{1'b1, 16'd0,     17'd1025, 8'd3, SRC_PRIO,   10'd512}},
    '{'{MODE_DRAIN, 10'd0,    1'b0, 16'd0},     1'b1,
      '{1'b1, 16'd0,     17'd1025, 8'd3, SRC_PRIO,   10'd512}},
    // partial send of a priority head, then finish it
    '{'{MODE_DRAIN, 10'd0,    1'b0, 16'd100},   1'b1,
      '{1'b1, 16'd0,     17'd925,  8'd3, SRC_PRIO,   10'd412}},
    '{'{MODE_ENQ,   10'd300,  1'b1, 16'd0},     1'b1,
      '{1'b1, 16'd0,     17'd1225, 8'd4, SRC_PRIO,   10'd412}},
    '{'{MODE_DRAIN, 10'd0,    1'b0, 16'd412},   1'b1,
      '{1'b1, 16'd0,     17'd813,  8'd3, SRC_PRIO,   10'd300}},
    '{'{MODE_DRAIN, 10'd0,    1'b1, 16'd300},   1'b1,
      '{1'b1, 16'd0,     17'd513,  8'd2, SRC_NORMAL, 10'd1}},
    '{'{MODE_DRAIN, 10'd1023, 1'b0, 16'd1},     1'b1,
      '{1'b1, 16'd0,     17'd512,  8'd1, SRC_NORMAL, 10'd512}},
    // partly sent normal head keeps the lead over a new priority message
    '{'{MODE_DRAIN, 10'd0,    1'b0, 16'd10},    1'b1,
      '{1'b1, 16'd0,     17'd502,  8'd1, SRC_NORMAL, 10'd502}},
    '{'{MODE_ENQ,   10'd200,  1'b1, 16'd0},     1'b1,
      '{1'b1, 16'd0,     17'd702,  8'd2, SRC_NORMAL, 10'd502}},
    '{'{MODE_DRAIN, 10'd0,    1'b0, 16'd502},   1'b1,
      '{1'b1, 16'd0,     17'd200,  8'd1, SRC_PRIO,   10'd200}},
    '{'{MODE_ENQ,   10'd341,  1'b0, 16'h5555},  1'b1,
      '{1'b1, 16'd0,     17'd541,  8'd2, SRC_PRIO,   10'd200}},
    // drain past the contents; the excess comes back
    '{'{MODE_DRAIN, 10'd682,  1'b0, 16'd1000},  1'b1,
      '{1'b1, 16'd459,   17'd0,    8'd0, SRC_NONE,   10'd0}},
    '{'{MODE_ENQ,   10'd256,  1'b0, 16'hAAAA},  1'b1,
      '{1'b1, 16'd0,     17'd256,  8'd1, SRC_NORMAL, 10'd256}},
    '{'{MODE_DRAIN, 10'd0,    1'b0, 16'hAAAA},  1'b1,
      '{1'b1, 16'd43434, 17'd0,    8'd0, SRC_NONE,   10'd0}},
    '{'{MODE_DRAIN, 10'd0,    1'b0, 16'h5555},  1'b1,
      '{1'b1, 16'd21845, 17'd0,    8'd0, SRC_NONE,   10'd0}},
    // left to the model
    '{'{MODE_ENQ,   10'd7,    1'b1, 16'd0},     1'b0,
      '{1'b0, 16'd0,     17'd0,    8'd0, SRC_NONE,   10'd0}},
    '{'{MODE_ENQ,   10'd9,    1'b0, 16'd0},     1'b0,
      '{1'b0, 16'd0,     17'd0,    8'd0, SRC_NONE,   10'd0}},
    '{'{MODE_DRAIN, 10'd0,    1'b0, 16'd12},    1'b0,
      '{1'b0, 16'd0,     17'd0,    8'd0, SRC_NONE,   10'd0}}
  };

  // Lane that sends next: a partly sent normal head, then priority, then normal
  function automatic int next_lane();
    if (lane_len[LANE_NORMAL].size() > 0 && lane_sent[LANE_NORMAL] > 0) return LANE_NORMAL;
    if (lane_len[LANE_PRIO].size() > 0) return LANE_PRIO;
    if (lane_len[LANE_NORMAL].size() > 0) return LANE_NORMAL;
    return NO_LANE;
  endfunction

  // Apply one item to the model and return the status it reports
  function automatic status_t queue_step(req_t r);
    status_t     s;
    int unsigned budget;
    int unsigned left;
    int          ln;
    int          retired;
    s.accepted  = 1'b0;
    s.left_over = '0;
    retired     = 0;
    if (r.mode == MODE_ENQ) begin
      n_enq++;
      ln = r.high_priority ? LANE_PRIO : LANE_NORMAL;
      if (r.msg_length == 0 || r.msg_length > MAX_MSG_BYTES) begin
        n_bad_len++;
      end else if (lane_len[ln].size() >= FIFO_DEPTH_DEF) begin
        n_full_refused++;
      end else begin
        lane_len[ln].push_back(r.msg_length);
        queued_total += r.msg_length;
        s.accepted = 1'b1;
      end
    end else begin
      n_drain++;
      budget = r.drain_bytes;
      while (budget > 0) begin
        ln = next_lane();
        if (ln == NO_LANE) break;
        left = lane_len[ln][0] - lane_sent[ln];
        if (budget >= left) begin
          budget -= left;
          queued_total -= left;
          void'(lane_len[ln].pop_front());
          lane_sent[ln] = 0;
          retired++;
        end else begin
          queued_total -= budget;
          lane_sent[ln] += budget;
          budget = 0;
        end
      end
      if (retired > 1) n_multi_retire++;
      s.accepted  = 1'b1;
      s.left_over = budget[DRAIN_W-1:0];
    end
    ln = next_lane();
    s.total_bytes = queued_total[TOTAL_BYTES_W-1:0];
    s.total_msgs  = TOTAL_MSG_W'(lane_len[LANE_NORMAL].size() + lane_len[LANE_PRIO].size());
    if (s.total_msgs > peak_msgs) peak_msgs = s.total_msgs;
    if (ln == NO_LANE) begin
      s.next_src = SRC_NONE;
      s.next_rem = '0;
    end else begin
      s.next_src = (ln == LANE_PRIO) ? SRC_PRIO : SRC_NORMAL;
      s.next_rem = MSG_LEN_W'(lane_len[ln][0] - lane_sent[ln]);
    end
    return s;
  endfunction

  // Random item shaped by the phase of the run
  function automatic req_t random_req(phase_t ph, logic one_hp);
    req_t r;
    int   enq_pct;
    int   pick;
    r.msg_length    = MSG_LEN_W'($urandom_range(1023));
    r.high_priority = 1'($urandom_range(1));
    r.drain_bytes   = DRAIN_W'($urandom_range(65535));
    case (ph)
      PH_FILL, PH_ONE_CLASS: enq_pct = 95;
      PH_DRAIN:              enq_pct = 10;
      default:               enq_pct = 55;
    endcase
    r.mode = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DRAIN;
    pick   = $urandom_range(99);
    if (r.mode == MODE_ENQ) begin
      if (ph == PH_ONE_CLASS) r.high_priority = one_hp;
      if (pick < 3)
        r.msg_length = (pick == 0) ? '0 : MSG_LEN_W'($urandom_range(1023, 513));
      else if (pick < 13)
        r.msg_length = MAX_MSG_BYTES;
      else if (ph == PH_MIXED)
        r.msg_length = MSG_LEN_W'($urandom_range(512, 1));
      else
        r.msg_length = MSG_LEN_W'($urandom_range(64, 1));
    end else begin
      case (ph)
        PH_FILL, PH_ONE_CLASS: r.drain_bytes = DRAIN_W'($urandom_range(40));
        PH_DRAIN: begin
          if (pick < 50)      r.drain_bytes = DRAIN_W'($urandom_range(2000, 1));
          else if (pick < 80) r.drain_bytes = DRAIN_W'($urandom_range(100));
        end
        default: begin
          if (pick < 10)      r.drain_bytes = '0;
          else if (pick < 80) r.drain_bytes = DRAIN_W'($urandom_range(600, 1));
        end
      endcase
    end
    return r;
  endfunction

  // Offer one item; valid stays high into the next item unless an idle falls
  task automatic send_item(input req_t r, input logic typed, input status_t typed_want);
    status_t s;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.mode          <= r.mode;
    in_chan.msg_length    <= r.msg_length;
    in_chan.high_priority <= r.high_priority;
    in_chan.drain_bytes   <= r.drain_bytes;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    s = queue_step(r);
    pending_status.push_back(typed ? typed_want : s);
  endtask

  // Result side stalls at random except in calm stretches
  always @(posedge clk) begin
    out_chan.ready <= rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    status_t got;
    status_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.accepted    = out_chan.accepted;
      got.left_over   = out_chan.bytes_left_over;
      got.total_bytes = out_chan.total_bytes;
      got.total_msgs  = out_chan.total_messages;
      got.next_src    = src_t'(out_chan.next_source);
      got.next_rem    = out_chan.next_remaining;
      results_seen++;
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: status transfer with nothing outstanding", $realtime);
      end else begin
        want = pending_status.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: status %0d mismatch", $realtime, results_seen);
            $display("  expected acc=%0d left=%0d bytes=%0d msgs=%0d src=%0d rem=%0d",
                     want.accepted, want.left_over, want.total_bytes,
                     want.total_msgs, want.next_src, want.next_rem);
            $display("  actual   acc=%0d left=%0d bytes=%0d msgs=%0d src=%0d rem=%0d",
                     got.accepted, got.left_over, got.total_bytes, got.total_msgs,
                     got.next_src, got.next_rem);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    phase_t ph_kind [8] = '{PH_FILL, PH_DRAIN, PH_MIXED, PH_ONE_CLASS,
                            PH_DRAIN, PH_MIXED, PH_FILL, PH_DRAIN};
    int     ph_len [8]  = '{150, 60, 120, 90, 40, 150, 100, 40};
    status_t none;
    logic   one_hp;
    none          = '0;
    calm          = 1'b0;
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.mode  <= MODE_ENQ;
    in_chan.msg_length    <= '0;
    in_chan.high_priority <= 1'b0;
    in_chan.drain_bytes   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // Random phases; the third runs with no idling on either side
    foreach (ph_kind[p]) begin
      calm   = (p == 2);
      one_hp = 1'($urandom_range(1));
      repeat (ph_len[p]) send_item(random_req(ph_kind[p], one_hp), 1'b0, none);
    end
    calm = 1'b0;
    in_chan.valid <= 1'b0;

    while (pending_status.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLE) @(posedge clk);

    mismatches += pending_status.size();
    $display("Covered %0d enqueues and %0d drains, %0d statuses checked, %0d mismatches",
             n_enq, n_drain, results_seen, mismatches);
    $display("Peak %0d queued; %0d refused full, %0d bad lengths, %0d multi-message drains",
             peak_msgs, n_full_refused, n_bad_len, n_multi_retire);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tcbdq_pkg.sv
rtl/core/tcbdq_if.sv
rtl/core/two_class_byte_drain_queue_unit.sv
bench/tb_top.sv
